@@ rtl/core/bq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq_pkg: shared constants, types and helpers for the binomial quantile unit
// Fixed-point widths, register indexes, state encoding and the table of
// inverses of odd divisors used for the exact binomial coefficient update.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int unsigned MAX_TRIALS_I = 32;
	localparam logic [5:0] MAX_TRIALS = 6'd32;

	localparam int unsigned FIX_W = 33;          // Q32 value, 1.0 included
	localparam int unsigned PROD_W = 2 * FIX_W;  // full product of two operands
	localparam int unsigned SUM_W = 38;          // up to 33 terms of at most 1.0
	localparam int unsigned COEF_W = 30;         // C(32,16) < 2^30

	localparam logic [FIX_W-1:0] FIX_ONE = 33'h1_0000_0000;
	localparam logic [16:0] Q_ONE = 17'd65536;

	// configuration register indexes
	localparam logic [1:0] REG_N_TRIALS = 2'd0;
	localparam logic [1:0] REG_SUCCESS_PROB = 2'd1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PRE  = 8'b0000_0010,
		ST_LOAD = 8'b0000_0100,
		ST_PROD = 8'b0000_1000,
		ST_TERM = 8'b0001_0000,
		ST_ACC  = 8'b0010_0000,
		ST_CMUL = 8'b0100_0000,
		ST_CDIV = 8'b1000_0000
	} state_t;

	typedef logic [31:0] inv_tbl_t [16];

	// inverse of an odd number mod 2^32 by Newton steps (elaboration only)
	function automatic logic [31:0] inv_odd(input logic [31:0] d);
		logic [31:0] x;
		x = d;
		for (int i = 0; i < 5; i++) begin
			x = x * (32'd2 - d * x);
		end
		return x;
	endfunction

	function automatic inv_tbl_t build_inv_tbl();
		inv_tbl_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = inv_odd(32'(2 * i + 1));
		end
		return t;
	endfunction

	// entry i holds the inverse of 2*i+1
	localparam inv_tbl_t INV_TBL = build_inv_tbl();

	// number of trailing zeros of a nonzero divisor in 1..32
	function automatic logic [2:0] trail_zeros(input logic [5:0] y);
		logic [2:0] t;
		t = 3'd5;
		for (int i = 4; i >= 0; i--) begin
			if (y[i]) begin
				t = 3'(i);
			end
		end
		return t;
	endfunction

endpackage

@@ rtl/core/binomial_quantile_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_quantile_unit: inverse binomial CDF by running summation
// Returns the smallest count x in 0..n whose binomial(n, p) cumulative
// probability reaches the requested level, or n when none does.
// ----------------------------------------------------------------------------
// Usage:
//   Config: write n_trials (index 0) and success_prob (index 1, Q1.16) on the
//   cfg_valid/cfg_ready channel while the unit is idle. cfg_ready is always
//   high; indexes past the list are dropped. Reset gives n = 1, p = 0.5.
//   Request: a beat is taken when start is high and busy is low; target_prob
//   is the level in Q1.16. busy stays high until the answer is out.
//   Answer: done pulses for one cycle with quantile valid. There is no
//   backpressure on this side; the receiver must take the beat.
// Operation:
//   One 33x33 multiplier is shared by everything under a small sequencer.
//   First it builds (1-p)^k, k = 0..n, into a small table (one multiply
//   per power). Then each count x costs five multiplies: (p^x)*(1-p)^(n-x),
//   C(n,x) times that, p^(x+1), and the coefficient update C*(n-x) followed
//   by an exact divide by x+1 done as a multiply by the odd inverse.
//   The next request may start in the cycle done is high. Reset clears the
//   sequencer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binomial_quantile_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [16:0] target_prob,
	// answer
	output logic        done,
	output logic [5:0]  quantile,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int unsigned FW = bq_pkg::FIX_W;
	localparam int unsigned PW = bq_pkg::PROD_W;
	localparam int unsigned SW = bq_pkg::SUM_W;
	localparam int unsigned CW = bq_pkg::COEF_W;

	// config registers
	logic [5:0]  n_trials_q;
	logic [16:0] success_prob_q;

	// sequencer
	bq_pkg::state_t state_q;
	bq_pkg::state_t state_d;
	logic [5:0]     cnt_q;          // power index while filling, then x
	logic           done_q;
	logic [5:0]     quantile_q;

	// datapath
	logic [PW-1:0] mul_q;           // shared multiplier output
	logic [FW-1:0] mul_a;
	logic [FW-1:0] mul_b;
	logic [FW-1:0] px_q;            // p^x
	logic [CW-1:0] c_q;             // C(n,x)
	logic [SW-1:0] sum_q;
	logic [FW-1:0] target_q;
	logic [FW-1:0] rd_q;            // (1-p)^(n-x) from the table

	// (1-p)^k table
	logic [FW-1:0] pcp_mem [0:bq_pkg::MAX_TRIALS_I];
	logic          wr_en;
	logic [5:0]    wr_addr;
	logic [FW-1:0] wr_data;
	logic          rd_en;
	logic [5:0]    rd_addr;

	logic [5:0]    n_sat;
	logic [16:0]   p16_sat;
	logic [16:0]   q16_sat;
	logic [FW-1:0] p_fix;
	logic [FW-1:0] pc_fix;
	logic [FW-1:0] fix_hi;
	logic [FW-1:0] term;
	logic [SW-1:0] sum_new;
	logic          finish;
	logic          accept;

	// exact divide by x+1: shift out the power of two, multiply by odd inverse
	logic [5:0]  div_y;
	logic [2:0]  div_sh;
	logic [5:0]  div_odd;
	logic [34:0] div_shifted;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != bq_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign quantile  = quantile_q;

	assign n_sat   = (n_trials_q > bq_pkg::MAX_TRIALS) ? bq_pkg::MAX_TRIALS : n_trials_q;
	assign p16_sat = (success_prob_q > bq_pkg::Q_ONE) ? bq_pkg::Q_ONE : success_prob_q;
	assign q16_sat = (target_prob > bq_pkg::Q_ONE) ? bq_pkg::Q_ONE : target_prob;
	assign p_fix   = {p16_sat, 16'b0};
	assign pc_fix  = bq_pkg::FIX_ONE - p_fix;

	// Q32 product; an operand of exactly 1.0 passes the other through
	assign fix_hi = mul_q[64:32];

	assign term    = (mul_q > {33'b0, bq_pkg::FIX_ONE}) ? bq_pkg::FIX_ONE : mul_q[FW-1:0];
	assign sum_new = sum_q + {5'b0, term};
	assign finish  = (sum_new >= {5'b0, target_q}) || (cnt_q == n_sat);

	assign div_y       = cnt_q + 6'd1;
	assign div_sh      = bq_pkg::trail_zeros(div_y);
	assign div_odd     = div_y >> div_sh;
	assign div_shifted = mul_q[34:0] >> div_sh;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			bq_pkg::ST_IDLE: begin
				mul_a = bq_pkg::FIX_ONE;
				mul_b = pc_fix;
			end
			bq_pkg::ST_PRE: begin
				mul_a = fix_hi;
				mul_b = pc_fix;
			end
			bq_pkg::ST_PROD: begin
				mul_a = px_q;
				mul_b = rd_q;
			end
			bq_pkg::ST_TERM: begin
				mul_a = {3'b0, c_q};
				mul_b = fix_hi;
			end
			bq_pkg::ST_ACC: begin
				mul_a = px_q;
				mul_b = p_fix;
			end
			bq_pkg::ST_CMUL: begin
				mul_a = {3'b0, c_q};
				mul_b = {27'b0, n_sat - cnt_q};
			end
			bq_pkg::ST_CDIV: begin
				mul_a = {1'b0, div_shifted[31:0]};
				mul_b = {1'b0, bq_pkg::INV_TBL[div_odd[4:1]]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// table ports
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = fix_hi;
		rd_en   = 1'b0;
		rd_addr = n_sat;
		case (state_q)
			bq_pkg::ST_IDLE: begin
				wr_en   = accept;
				wr_addr = '0;
				wr_data = bq_pkg::FIX_ONE;
			end
			bq_pkg::ST_PRE: begin
				wr_en = 1'b1;
			end
			bq_pkg::ST_LOAD: begin
				rd_en = 1'b1;
			end
			bq_pkg::ST_ACC: begin
				rd_en   = !finish;
				rd_addr = n_sat - cnt_q - 6'd1;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bq_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (n_sat == '0) ? bq_pkg::ST_LOAD : bq_pkg::ST_PRE;
				end
			end
			bq_pkg::ST_PRE: begin
				if (cnt_q == n_sat) begin
					state_d = bq_pkg::ST_LOAD;
				end
			end
			bq_pkg::ST_LOAD: state_d = bq_pkg::ST_PROD;
			bq_pkg::ST_PROD: state_d = bq_pkg::ST_TERM;
			bq_pkg::ST_TERM: state_d = bq_pkg::ST_ACC;
			bq_pkg::ST_ACC:  state_d = finish ? bq_pkg::ST_IDLE : bq_pkg::ST_CMUL;
			bq_pkg::ST_CMUL: state_d = bq_pkg::ST_CDIV;
			bq_pkg::ST_CDIV: state_d = bq_pkg::ST_PROD;
			default:         state_d = bq_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bq_pkg::ST_IDLE;
			cnt_q          <= '0;
			done_q         <= 1'b0;
			n_trials_q     <= 6'd1;
			success_prob_q <= 17'd32768;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bq_pkg::ST_ACC) && finish;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bq_pkg::REG_N_TRIALS:     n_trials_q <= cfg_data[5:0];
					bq_pkg::REG_SUCCESS_PROB: success_prob_q <= cfg_data;
					default:                  ;
				endcase
			end
			case (state_q)
				bq_pkg::ST_IDLE: if (accept) cnt_q <= 6'd1;
				bq_pkg::ST_PRE:  if (cnt_q != n_sat) cnt_q <= cnt_q + 6'd1;
				bq_pkg::ST_LOAD: cnt_q <= '0;
				bq_pkg::ST_CDIV: cnt_q <= cnt_q + 6'd1;
				default:         ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= {33'b0, mul_a} * {33'b0, mul_b};
		case (state_q)
			bq_pkg::ST_IDLE: begin
				if (accept) begin
					sum_q    <= '0;
					px_q     <= bq_pkg::FIX_ONE;
					c_q      <= CW'(1);
					target_q <= {q16_sat, 16'b0};
				end
			end
			bq_pkg::ST_PROD: begin
				// coefficient from the previous divide step
				if (cnt_q != '0) c_q <= mul_q[CW-1:0];
			end
			bq_pkg::ST_ACC: begin
				sum_q <= sum_new;
				if (finish) quantile_q <= cnt_q;
			end
			bq_pkg::ST_CMUL: px_q <= fix_hi;
			default: ;
		endcase
	end

	// power table
	always_ff @(posedge clk) begin
		if (wr_en) pcp_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= pcp_mem[rd_addr];
	end

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken without going busy");

	a_answer_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quantile <= n_sat)) else $error("answer beyond trial count");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bq_pkg::ST_PROD) |-> (cnt_q <= n_sat))
		else $error("walk ran past n");

	a_coef_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bq_pkg::ST_TERM) |-> (c_q != '0))
		else $error("binomial coefficient lost");

endmodule
